@@ rtl/ssd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and lookup functions of the seven-segment scan
// driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Field widths of the scan position cover the largest supported arrangement
  // (four displays of eight digits each).
  localparam int unsigned DispW   = 2;
  localparam int unsigned DigitW  = 3;
  localparam int unsigned ValueW  = 14;
  localparam int unsigned DwellW  = 16;
  localparam int unsigned SegW    = 8;
  localparam int unsigned BcdW    = 4;

  localparam logic [ValueW-1:0] CLAMP_LIMIT   = 14'd1000;
  localparam logic [9:0]        CLAMP_VALUE   = 10'd990;
  localparam logic [SegW-1:0]   DP_BIT        = 8'b1000_0000;
  localparam logic [DispW-1:0]  GREEN_DISPLAY = 2'd0;
  localparam logic [DigitW-1:0] DP_DIGIT      = 3'd1;

  // Kind of an input transaction.
  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_LOAD = 1'b1
  } mode_e;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic [DispW-1:0]  disp;
  } pos_t;

  // Hundreds, tens and units of a clamped reading.
  typedef struct packed {
    logic [BcdW-1:0] hund;
    logic [BcdW-1:0] tens;
    logic [BcdW-1:0] units;
  } bcd3_t;

  // Readings at or above the limit clamp, so the value always fits 10 bits and
  // the divisions by 10 and 100 become exact reciprocal multiplications.
  function automatic bcd3_t split_reading(input logic [ValueW-1:0] value);
    logic [9:0]  v;
    logic [17:0] prod10;
    logic [15:0] prod100;
    logic [6:0]  tens_all;
    logic [3:0]  hund;
    logic [9:0]  units_w;
    logic [6:0]  tens_w;
    bcd3_t       res;
    v        = (value >= CLAMP_LIMIT) ? CLAMP_VALUE : value[9:0];
    prod10   = 18'(v) * 18'd205;
    prod100  = 16'(v) * 16'd41;
    tens_all = prod10[17:11];
    hund     = prod100[15:12];
    units_w  = v - ({3'd0, tens_all} * 10'd10);
    tens_w   = tens_all - ({3'd0, hund} * 7'd10);
    res.hund  = hund;
    res.tens  = tens_w[3:0];
    res.units = units_w[3:0];
    return res;
  endfunction

  // Segment pattern, bit 0 = A .. bit 6 = G. Codes above nine wrap modulo ten.
  function automatic logic [SegW-1:0] seg_lookup(input logic [BcdW-1:0] digit);
    logic [SegW-1:0] seg;
    unique case (digit) inside
      4'd0, 4'd10: seg = 8'h3F;
      4'd1, 4'd11: seg = 8'h06;
      4'd2, 4'd12: seg = 8'h5B;
      4'd3, 4'd13: seg = 8'h4F;
      4'd4, 4'd14: seg = 8'h66;
      4'd5, 4'd15: seg = 8'h6D;
      4'd6:        seg = 8'h7C;
      4'd7:        seg = 8'h07;
      4'd8:        seg = 8'h7F;
      4'd9:        seg = 8'h67;
      default:     seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Digit select codes for the two-by-three board wiring; anything else is 0.
  function automatic logic [SegW-1:0] sel_lookup(input pos_t pos);
    logic [SegW-1:0] sel;
    unique case ({pos.disp, pos.digit})
      {2'd0, 3'd0}: sel = 8'h3C;
      {2'd0, 3'd1}: sel = 8'h5C;
      {2'd0, 3'd2}: sel = 8'h9C;
      {2'd1, 3'd0}: sel = 8'h18;
      {2'd1, 3'd1}: sel = 8'h14;
      {2'd1, 3'd2}: sel = 8'h0C;
      default:      sel = 8'h00;
    endcase
    return sel;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ssd_digit_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_digit_mem
// Digit memory, one row of decimal digits per display. A load splits the
// reading and writes a whole row; a scan read returns a row in the next cycle.
// ----------------------------------------------------------------------------
module ssd_digit_mem #(
  parameter int unsigned NUM_DISPLAYS       = 2,
  parameter int unsigned DIGITS_PER_DISPLAY = 3
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    wr_en_i,
  input  wire logic                                    wr_disp_i,
  input  wire logic [ssd_pkg::ValueW-1:0]              wr_value_i,
  input  wire logic                                    rd_en_i,
  input  wire logic [ssd_pkg::DispW-1:0]               rd_disp_i,
  output logic [DIGITS_PER_DISPLAY-1:0][ssd_pkg::BcdW-1:0] rd_row_o
);

  localparam int unsigned RowW = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;

  typedef logic [DIGITS_PER_DISPLAY-1:0][ssd_pkg::BcdW-1:0] row_t;

  row_t                  mem_q [NUM_DISPLAYS];
  logic [NUM_DISPLAYS-1:0] row_valid_q;
  row_t                  rd_row_q;
  row_t                  wr_row;
  ssd_pkg::bcd3_t        bcd;
  logic                  wr_ok;
  logic [RowW-1:0]       wr_addr;
  logic [RowW-1:0]       rd_addr;

  // Digit index 0 is the most significant; digits above hundreds are zero.
  always_comb begin
    bcd = ssd_pkg::split_reading(wr_value_i);
    for (int k = 0; k < int'(DIGITS_PER_DISPLAY); k++) begin
      case (int'(DIGITS_PER_DISPLAY) - 1 - k)
        0:       wr_row[k] = bcd.units;
        1:       wr_row[k] = bcd.tens;
        2:       wr_row[k] = bcd.hund;
        default: wr_row[k] = '0;
      endcase
    end
  end

  assign wr_ok   = wr_en_i && (32'(wr_disp_i) < NUM_DISPLAYS);
  assign wr_addr = RowW'(wr_disp_i);
  assign rd_addr = rd_disp_i[RowW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (wr_ok) begin
      row_valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_addr] <= wr_row;
    end
  end

  // A row never written since reset reads as all zero digits.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= row_valid_q[rd_addr] ? mem_q[rd_addr] : '0;
    end
  end

  assign rd_row_o = rd_row_q;

endmodule
`default_nettype wire

@@ rtl/ssd_scan_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_scan_ctrl
// Dwell counter and scan position. Each tick holds the current position until
// the dwell count expires, then steps display first and digit second.
// ----------------------------------------------------------------------------
module ssd_scan_ctrl #(
  parameter int unsigned NUM_DISPLAYS       = 2,
  parameter int unsigned DIGITS_PER_DISPLAY = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic [ssd_pkg::DwellW-1:0]    dwell_ticks_i,
  output ssd_pkg::pos_t                      pos_o
);

  localparam logic [ssd_pkg::DispW-1:0]  LastDisp  = ssd_pkg::DispW'(NUM_DISPLAYS - 1);
  localparam logic [ssd_pkg::DigitW-1:0] LastDigit =
    ssd_pkg::DigitW'(DIGITS_PER_DISPLAY - 1);

  logic [ssd_pkg::DwellW-1:0] dwell_count_q, dwell_count_d;
  logic [ssd_pkg::DwellW-1:0] count_inc;
  logic [ssd_pkg::DwellW-1:0] limit;
  logic                       expire;
  ssd_pkg::pos_t              pos_q, pos_d;

  // A dwell of zero behaves as one; a count that wraps also expires.
  assign count_inc = dwell_count_q + 16'd1;
  assign limit     = (dwell_ticks_i == '0) ? 16'd1 : dwell_ticks_i;
  assign expire    = (count_inc >= limit) || (count_inc == '0);

  always_comb begin
    dwell_count_d = dwell_count_q;
    pos_d         = pos_q;
    if (tick_i) begin
      dwell_count_d = expire ? '0 : count_inc;
      if (expire) begin
        if (pos_q.disp == LastDisp) begin
          pos_d.disp  = '0;
          pos_d.digit = (pos_q.digit == LastDigit) ? '0 : pos_q.digit + 3'd1;
        end else begin
          pos_d.disp = pos_q.disp + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_count_q <= '0;
      pos_q         <= '0;
    end else begin
      dwell_count_q <= dwell_count_d;
      pos_q         <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule
`default_nettype wire

@@ rtl/ssd_seg_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_seg_out
// Output stage. Picks the shown digit from the memory row, encodes segments
// and select code, and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module ssd_seg_out #(
  parameter int unsigned DIGITS_PER_DISPLAY = 3
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic                                            rd_valid_i,
  input  ssd_pkg::pos_t                                        rd_pos_i,
  input  wire logic [DIGITS_PER_DISPLAY-1:0][ssd_pkg::BcdW-1:0] rd_row_i,
  output logic                                                 advance_o,
  output logic                                                 out_valid_o,
  input  wire logic                                            out_ready_i,
  output logic [ssd_pkg::SegW-1:0]                             sel_pattern_o,
  output logic [ssd_pkg::SegW-1:0]                             seg_pattern_o
);

  localparam int unsigned DigW = (DIGITS_PER_DISPLAY > 1) ? $clog2(DIGITS_PER_DISPLAY) : 1;

  logic                      out_valid_q;
  logic [ssd_pkg::SegW-1:0]  sel_q, seg_q;
  logic [ssd_pkg::SegW-1:0]  seg_d, sel_d;
  logic [ssd_pkg::BcdW-1:0]  digit;

  assign advance_o = !out_valid_q || out_ready_i;

  always_comb begin
    digit = rd_row_i[rd_pos_i.digit[DigW-1:0]];
    seg_d = ssd_pkg::seg_lookup(digit);
    if (rd_pos_i.digit == ssd_pkg::DP_DIGIT) begin
      seg_d = seg_d | ssd_pkg::DP_BIT;
    end
    // The green display is wired common anode.
    if (rd_pos_i.disp == ssd_pkg::GREEN_DISPLAY) begin
      seg_d = ~seg_d;
    end
    sel_d = ssd_pkg::sel_lookup(rd_pos_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= rd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && rd_valid_i) begin
      sel_q <= sel_d;
      seg_q <= seg_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sel_pattern_o = sel_q;
  assign seg_pattern_o = seg_q;

endmodule
`default_nettype wire

@@ rtl/seven_segment_scan_driver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A tick transaction's result is registered first by the digit memory read
// and then by the output register, which holds it until it is taken.
// Throughput: one transaction per cycle, ticks and loads alike; the input
// stalls only while the output register holds a result that is not taken.
// Reset: asynchronous, active low; scan position, dwell count and pipeline
// valids clear, dwell_ticks returns to 1 and all stored digits read as zero.
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed driver for several multi-digit seven-segment displays, with
// the digits kept in a row-per-display memory.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
  parameter int unsigned NUM_DISPLAYS       = 2,
  parameter int unsigned DIGITS_PER_DISPLAY = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ssd_pkg::DwellW-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          mode_i,
  input  wire logic                          display_sel_i,
  input  wire logic [ssd_pkg::ValueW-1:0]    reading_tenths_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ssd_pkg::SegW-1:0]           sel_pattern_o,
  output logic [ssd_pkg::SegW-1:0]           seg_pattern_o
);

  logic [ssd_pkg::DwellW-1:0] dwell_ticks_q;
  logic                       tick_fire, load_fire;
  logic                       rd_valid_q;
  ssd_pkg::pos_t              rd_pos_q;
  ssd_pkg::pos_t              scan_pos;
  logic                       advance;
  logic [DIGITS_PER_DISPLAY-1:0][ssd_pkg::BcdW-1:0] rd_row;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dwell_ticks_q <= cfg_wdata_i;
    end
  end

  // The read stage may only refill when its row can move to the output.
  assign in_ready_o = !rd_valid_q || advance;
  assign tick_fire  = in_valid_i && in_ready_o && (mode_i == ssd_pkg::MODE_TICK);
  assign load_fire  = in_valid_i && in_ready_o && (mode_i == ssd_pkg::MODE_LOAD);

  ssd_scan_ctrl #(
    .NUM_DISPLAYS      (NUM_DISPLAYS),
    .DIGITS_PER_DISPLAY(DIGITS_PER_DISPLAY)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_fire),
    .dwell_ticks_i(dwell_ticks_q),
    .pos_o        (scan_pos)
  );

  // Loads write at their accept edge, so a later tick always reads new data.
  ssd_digit_mem #(
    .NUM_DISPLAYS      (NUM_DISPLAYS),
    .DIGITS_PER_DISPLAY(DIGITS_PER_DISPLAY)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load_fire),
    .wr_disp_i (display_sel_i),
    .wr_value_i(reading_tenths_i),
    .rd_en_i   (tick_fire),
    .rd_disp_i (scan_pos.disp),
    .rd_row_o  (rd_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (tick_fire) begin
      rd_valid_q <= 1'b1;
    end else if (advance) begin
      rd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      rd_pos_q <= scan_pos;
    end
  end

  ssd_seg_out #(
    .DIGITS_PER_DISPLAY(DIGITS_PER_DISPLAY)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_valid_i   (rd_valid_q),
    .rd_pos_i     (rd_pos_q),
    .rd_row_i     (rd_row),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sel_pattern_o(sel_pattern_o),
    .seg_pattern_o(seg_pattern_o)
  );

  // A read that cannot move on keeps its position for the next cycle.
  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q && !advance |=> rd_valid_q && $stable(rd_pos_q))
    else $error("read stage lost or changed a stalled transaction");

  // A load never moves the scan.
  a_load_keeps_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> $stable(scan_pos))
    else $error("load transaction changed the scan position");

  // A read stage that moves on always lands in the output register.
  a_read_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q && advance |=> out_valid_o)
    else $error("result dropped between read stage and output");

endmodule
`default_nettype wire

@@ tb/seven_segment_scan_driver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_tb
// Self-checking testbench for the multiplexed seven-segment scan driver.
// A directed block of loads and ticks is followed by random traffic under a
// series of dwell settings. Every accepted transaction runs through a local
// model of the digit store and the scan counter, and every result is checked
// in order against it. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_tb;

  localparam int unsigned NUM_DISP     = 2;
  localparam int unsigned DIGITS       = 3;
  localparam int unsigned SCAN_LEN     = NUM_DISP * DIGITS;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 30;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef enum logic {DISP_GREEN = 1'b0, DISP_RED = 1'b1} disp_e;

  typedef struct packed {
    ssd_pkg::mode_e             mode;
    disp_e                      display_sel;
    logic [ssd_pkg::ValueW-1:0] reading;
  } scan_item_t;

  typedef struct packed {
    logic [ssd_pkg::SegW-1:0] sel;
    logic [ssd_pkg::SegW-1:0] seg;
  } scan_result_t;

  logic                       clk_i            = 1'b0;
  logic                       rst_ni           = 1'b0;
  logic                       cfg_valid_i      = 1'b0;
  logic                       cfg_ready_o;
  logic [ssd_pkg::DwellW-1:0] cfg_wdata_i      = '0;
  logic                       in_valid_i       = 1'b0;
  logic                       in_ready_o;
  logic                       mode_i           = 1'b0;
  logic                       display_sel_i    = 1'b0;
  logic [ssd_pkg::ValueW-1:0] reading_tenths_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i      = 1'b0;
  logic [ssd_pkg::SegW-1:0]   sel_pattern_o;
  logic [ssd_pkg::SegW-1:0]   seg_pattern_o;

  seven_segment_scan_driver #(
    .NUM_DISPLAYS      (NUM_DISP),
    .DIGITS_PER_DISPLAY(DIGITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .display_sel_i   (display_sel_i),
    .reading_tenths_i(reading_tenths_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sel_pattern_o   (sel_pattern_o),
    .seg_pattern_o   (seg_pattern_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the display state.
  logic [ssd_pkg::BcdW-1:0]   shown_digits [0:NUM_DISP-1][0:DIGITS-1];
  int unsigned                scan_pos     = 0;
  logic [ssd_pkg::DwellW-1:0] dwell_count  = '0;
  logic [ssd_pkg::DwellW-1:0] dwell_ticks  = 16'd1;

  logic [ssd_pkg::SegW-1:0] seg_font [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                               8'h6D, 8'h7C, 8'h07, 8'h7F, 8'h67};
  logic [ssd_pkg::SegW-1:0] sel_codes [0:NUM_DISP-1][0:DIGITS-1] =
    '{'{8'h3C, 8'h5C, 8'h9C}, '{8'h18, 8'h14, 8'h0C}};

  scan_item_t   pending_items [$];
  scan_result_t expected_frames [$];

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_loads    = 0;
  int unsigned n_clamped  = 0;
  int unsigned n_checked  = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors   = 0;
  int unsigned cycles     = 0;

  initial begin
    for (int d = 0; d < NUM_DISP; d++)
      for (int k = 0; k < DIGITS; k++)
        shown_digits[d][k] = '0;
  end

  task automatic report_error(input string msg);
    if (n_errors < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Applies one accepted transaction: a load updates the digits, a tick yields
  // the current position's frame and moves the scan once the dwell expires.
  function automatic void predict_frame(input scan_item_t item);
    int unsigned  value;
    int unsigned  d;
    int unsigned  k;
    int unsigned  limit;
    scan_result_t frame;
    if (item.mode == ssd_pkg::MODE_LOAD) begin
      value = (item.reading >= ssd_pkg::CLAMP_LIMIT) ? 32'(ssd_pkg::CLAMP_VALUE)
                                                     : 32'(item.reading);
      shown_digits[item.display_sel][0] = ssd_pkg::BcdW'(value / 100);
      shown_digits[item.display_sel][1] = ssd_pkg::BcdW'((value / 10) % 10);
      shown_digits[item.display_sel][2] = ssd_pkg::BcdW'(value % 10);
      n_loads++;
      if (item.reading >= ssd_pkg::CLAMP_LIMIT) n_clamped++;
    end else begin
      k = scan_pos / NUM_DISP;
      d = scan_pos % NUM_DISP;
      frame.seg = seg_font[shown_digits[d][k]];
      if (k == 1) frame.seg = frame.seg | ssd_pkg::DP_BIT;
      if (d == ssd_pkg::GREEN_DISPLAY) frame.seg = ~frame.seg;
      frame.sel = sel_codes[d][k];
      expected_frames.push_back(frame);
      // A dwell setting of zero behaves like one.
      limit = (dwell_ticks == '0) ? 1 : dwell_ticks;
      dwell_count = dwell_count + 16'd1;
      if (dwell_count >= limit || dwell_count == '0) begin
        dwell_count = '0;
        scan_pos = (scan_pos + 1) % SCAN_LEN;
      end
      n_ticks++;
    end
  endfunction

  function automatic scan_item_t make_item(input ssd_pkg::mode_e mode, input disp_e disp,
                                           input logic [ssd_pkg::ValueW-1:0] reading);
    scan_item_t item;
    item.mode        = mode;
    item.display_sel = disp;
    item.reading     = reading;
    return item;
  endfunction

  function automatic scan_item_t random_item();
    scan_item_t item;
    item.mode        = ($urandom_range(0, 9) < 3) ? ssd_pkg::MODE_LOAD : ssd_pkg::MODE_TICK;
    item.display_sel = disp_e'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: item.reading = ssd_pkg::ValueW'($urandom_range(0, 999));
      6:                item.reading = ssd_pkg::ValueW'($urandom_range(1000, 16383));
      7: begin
        case ($urandom_range(0, 4))
          0:       item.reading = 14'd0;
          1:       item.reading = 14'd999;
          2:       item.reading = 14'd1000;
          3:       item.reading = 14'd990;
          default: item.reading = 14'd16383;
        endcase
      end
      default:          item.reading = ssd_pkg::ValueW'($urandom_range(0, 16383));
    endcase
    return item;
  endfunction

  task automatic queue_item(input scan_item_t item);
    pending_items.push_back(item);
    n_queued++;
  endtask

  // Waits until every queued transaction is taken and every frame has arrived.
  task automatic drain();
    while (n_accepted < n_queued || expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dwell(input logic [ssd_pkg::DwellW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dwell_ticks = value;
    n_settings++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : sender
    scan_item_t item;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        item = make_item(ssd_pkg::mode_e'(mode_i), disp_e'(display_sel_i),
                         reading_tenths_i);
        predict_frame(item);
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0 || pending_items.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          item = pending_items.pop_front();
          in_valid_i       <= 1'b1;
          mode_i           <= item.mode;
          display_sel_i    <= item.display_sel;
          reading_tenths_i <= item.reading;
          burst_left--;
        end
      end
    end
  end

  // Receiver: checks each frame and stalls in stretches of varying style.
  int unsigned stall_style = 0;
  int unsigned style_left  = 0;

  always @(posedge clk_i) begin : receiver
    scan_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          report_error($sformatf("frame sel=%02h seg=%02h with nothing expected",
                                 sel_pattern_o, seg_pattern_o));
        end else begin
          want = expected_frames.pop_front();
          if (sel_pattern_o !== want.sel)
            report_error($sformatf("sel_pattern got %02h expected %02h",
                                   sel_pattern_o, want.sel));
          if (seg_pattern_o !== want.seg)
            report_error($sformatf("seg_pattern got %02h expected %02h",
                                   seg_pattern_o, want.seg));
          n_checked++;
        end
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(16, 160);
      end
      style_left--;
      case (stall_style)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 3) != 0);
        2:       out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= (style_left % 12) < 4;
      endcase
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[seven_segment_scan_driver] ERROR");
      $finish;
    end
  end

  initial begin : sequencer
    logic [ssd_pkg::DwellW-1:0] dwell_plan [0:6];
    dwell_plan[0] = 16'd0;
    dwell_plan[1] = 16'd65535;
    dwell_plan[2] = 16'd2;
    dwell_plan[3] = 16'd3;
    dwell_plan[4] = 16'($urandom_range(4, 12));
    dwell_plan[5] = 16'd5;
    dwell_plan[6] = 16'd1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed block: loads between ticks must not disturb the scan, and with
    // a dwell of one every tick shows the next position.
    write_dwell(16'd1);
    queue_item(make_item(ssd_pkg::MODE_LOAD, DISP_GREEN, 14'd16383));
    queue_item(make_item(ssd_pkg::MODE_LOAD, DISP_RED, 14'd0));
    repeat (SCAN_LEN) queue_item(make_item(ssd_pkg::MODE_TICK, DISP_GREEN, 14'd0));
    queue_item(make_item(ssd_pkg::MODE_LOAD, DISP_GREEN, 14'd123));
    queue_item(make_item(ssd_pkg::MODE_LOAD, DISP_RED, 14'd1000));
    repeat (SCAN_LEN) queue_item(make_item(ssd_pkg::MODE_TICK, DISP_RED, 14'd16383));
    queue_item(make_item(ssd_pkg::MODE_LOAD, DISP_GREEN, 14'd456));
    queue_item(make_item(ssd_pkg::MODE_LOAD, DISP_RED, 14'd789));
    repeat (SCAN_LEN) queue_item(make_item(ssd_pkg::MODE_TICK, DISP_GREEN, 14'd0));
    drain();

    // Each phase waits for every frame before the dwell setting changes.
    for (int p = 0; p < 7; p++) begin
      write_dwell(dwell_plan[p]);
      repeat (PHASE_ITEMS) queue_item(random_item());
      drain();
    end

    if (expected_frames.size() != 0)
      report_error($sformatf("%0d frames never arrived", expected_frames.size()));

    $display("Covered %0d ticks and %0d loads (%0d clamped) under %0d dwell settings.",
             n_ticks, n_loads, n_clamped, n_settings);
    $display("Checked %0d frames, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("[seven_segment_scan_driver] OK");
    end else begin
      $display("[seven_segment_scan_driver] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ssd_pkg.sv
rtl/ssd_digit_mem.sv
rtl/ssd_scan_ctrl.sv
rtl/ssd_seg_out.sv
rtl/seven_segment_scan_driver.sv
tb/seven_segment_scan_driver_tb.sv
